FILE: hdl/mesh_address_abbreviation_encoder_assert.svh
// Assertion macros used by the encoder's top-level RTL file.
`ifndef MESH_ADDRESS_ABBREVIATION_ENCODER_ASSERT_SVH
`define MESH_ADDRESS_ABBREVIATION_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MAAE_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MAAE_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle implication failed");

`endif

FILE: hdl/maae_pkg.sv
// Types, codes and helper functions of the address abbreviation encoder.
`default_nettype none
package maae_pkg;

  localparam int unsigned CacheEntriesDef = 1024;
  localparam int unsigned SlotRows = 256;

  localparam logic [1:0] CMD_ENCODE     = 2'd0;
  localparam logic [1:0] CMD_SET_SENDER = 2'd1;
  localparam logic [1:0] CMD_UNSET      = 2'd2;
  localparam logic [1:0] CMD_CLEAR_PREV = 2'd3;

  localparam logic [7:0] CODE_SELF   = 8'h04;
  localparam logic [7:0] CODE_PREV   = 8'h03;
  localparam logic [7:0] CODE_BCAST  = 8'h0f;
  localparam logic [7:0] CODE_FULL   = 8'h08;
  localparam logic [7:0] CODE_PREFIX = 8'h06;
  localparam logic [7:0] MIN_FIRST   = 8'h10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] addr_w0;
    logic [63:0] addr_w1;
    logic [63:0] addr_w2;
    logic [63:0] addr_w3;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic decide;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic clear_done;
    logic emit_done;
  } sts_t;

  // Floor of log2, capped at 24 bits of address prefix.
  function automatic int unsigned cache_lg(input int unsigned n);
    int unsigned lg;
    lg = 0;
    while (lg < 24 && (n >> (lg + 1)) != 0) lg++;
    return lg;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/maae_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module maae_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 256,
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/maae_ctrl.sv
// Controller state machine of the encoder.
`default_nettype none
module maae_ctrl import maae_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] cmd,
  input  wire sts_t       sts,
  output ctl_t            ctl,
  output logic            busy
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_LOOK   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    ctl        = '0;
    busy       = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
        if (start && cmd == CMD_ENCODE) state_nxt = S_LOOK;
      end
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      S_LOOK: state_nxt = S_DECIDE;
      S_DECIDE: begin
        ctl.decide = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        ctl.emit = 1'b1;
        if (sts.emit_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

FILE: hdl/maae_dp.sv
// Datapath of the encoder: address registers, cache and slot memories, byte emitter.
`default_nettype none
module maae_dp import maae_pkg::*; #(
  parameter int unsigned CACHE_ENTRIES = CacheEntriesDef
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_item,
  input  wire ctl_t     ctl,
  output sts_t          sts,
  output logic          out_valid,
  output out_item_t     out_item
);
  localparam int unsigned LG   = cache_lg(CACHE_ENTRIES);
  localparam int unsigned AW   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned MAXD = (CACHE_ENTRIES > SlotRows) ? CACHE_ENTRIES : SlotRows;
  localparam int unsigned CW   = $clog2(MAXD);

  localparam logic [2:0] M_ERR = 3'd0, M_SELF = 3'd1, M_PREV = 3'd2, M_BCAST = 3'd3;
  localparam logic [2:0] M_FULL = 3'd4, M_PREFIX = 3'd5, M_RAW = 3'd6;

  logic [255:0] addr_r, sender_r, prev_r;
  logic         sender_vld_r;
  logic [7:0]   next_idx_r, idx_byte_r;
  logic [2:0]   mode_r, mode;
  logic [5:0]   len_r, len, pos_r, bidx;
  logic [CW-1:0] clr_cnt_r;
  logic         out_valid_r;
  out_item_t    out_r, out_nxt;

  logic [LG-1:0] cidx;
  logic [AW-1:0] c_waddr;
  logic [255:0]  c_rdata, c_wdata;
  logic          c_we;
  logic [7:0]    first, s_waddr;
  logic [1:0]    s_rdata, s_wdata, s_new;
  logic          s_we;
  logic          hit, invalid, is_self, is_prev, is_bc, alloc;

  assign cidx  = addr_r[255 -: LG] ^ LG'(1);
  assign first = addr_r[255:248];

  assign c_we    = ctl.clear ? (32'(clr_cnt_r) < 32'(CACHE_ENTRIES)) : (ctl.decide && !hit);
  assign c_waddr = ctl.clear ? clr_cnt_r[AW-1:0] : AW'(cidx);
  assign c_wdata = ctl.clear ? '0 : addr_r;

  maae_ram #(.W(256), .D(CACHE_ENTRIES)) u_cache (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(AW'(cidx)), .rdata(c_rdata)
  );

  // Each row keeps only whether its two slots are taken.
  assign s_new   = s_rdata[0] ? 2'b10 : 2'b01;
  assign s_we    = ctl.clear ? (32'(clr_cnt_r) < 32'(SlotRows)) : (ctl.decide && alloc);
  assign s_waddr = ctl.clear ? clr_cnt_r[7:0] : first;
  assign s_wdata = ctl.clear ? 2'b00 : (s_rdata | s_new);

  maae_ram #(.W(2), .D(SlotRows)) u_slots (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(first), .rdata(s_rdata)
  );

  assign hit     = (c_rdata == addr_r);
  assign invalid = (first < MIN_FIRST);
  assign is_self = sender_vld_r && (addr_r == sender_r);
  assign is_prev = (addr_r == prev_r);
  assign is_bc   = &addr_r[255:64];
  assign alloc   = !invalid && !is_self && !is_prev && !is_bc && !(&s_rdata)
                   && (next_idx_r != 8'd0);

  always_comb begin
    if (invalid) begin
      mode = M_ERR; len = 6'd1;
    end else if (is_self) begin
      mode = M_SELF; len = 6'd1;
    end else if (is_prev) begin
      mode = M_PREV; len = 6'd1;
    end else if (is_bc) begin
      mode = M_BCAST; len = 6'd9;
    end else if (alloc) begin
      mode = M_FULL; len = 6'd34;
    end else if (hit) begin
      mode = M_PREFIX; len = 6'd8;
    end else begin
      mode = M_RAW; len = 6'd32;
    end
  end

  always_comb begin
    case (mode_r)
      M_BCAST: bidx = pos_r + 6'd23;
      M_RAW:   bidx = pos_r;
      default: bidx = pos_r - 6'd1;
    endcase
    out_nxt.out_byte = addr_r[8 * (31 - int'(bidx[4:0])) +: 8];
    out_nxt.status   = 1'b0;
    out_nxt.last     = (pos_r == len_r - 6'd1);
    case (mode_r)
      M_ERR: begin
        out_nxt.out_byte = 8'h00;
        out_nxt.status   = 1'b1;
      end
      M_SELF: out_nxt.out_byte = CODE_SELF;
      M_PREV: out_nxt.out_byte = CODE_PREV;
      M_BCAST: if (pos_r == 6'd0) out_nxt.out_byte = CODE_BCAST;
      M_FULL: begin
        if (pos_r == 6'd0) out_nxt.out_byte = CODE_FULL;
        else if (pos_r == 6'd33) out_nxt.out_byte = idx_byte_r;
      end
      M_PREFIX: if (pos_r == 6'd0) out_nxt.out_byte = CODE_PREFIX;
      default: ;
    endcase
  end

  assign sts.emit_done  = out_nxt.last;
  assign sts.clear_done = (32'(clr_cnt_r) == 32'(MAXD - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sender_vld_r <= 1'b0;
      prev_r       <= '0;
      next_idx_r   <= 8'd1;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit;
      if (ctl.clear) clr_cnt_r <= clr_cnt_r + CW'(1);
      if (ctl.load) begin
        case (in_item.cmd)
          CMD_SET_SENDER: sender_vld_r <= 1'b1;
          CMD_UNSET:      sender_vld_r <= 1'b0;
          CMD_CLEAR_PREV: prev_r[255:248] <= 8'h00;
          default: ;
        endcase
      end
      if (ctl.decide) begin
        if (alloc) next_idx_r <= next_idx_r + 8'd1;
        if (!invalid) prev_r <= addr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (in_item.cmd == CMD_ENCODE)
        addr_r <= {in_item.addr_w0, in_item.addr_w1, in_item.addr_w2, in_item.addr_w3};
      if (in_item.cmd == CMD_SET_SENDER)
        sender_r <= {in_item.addr_w0, in_item.addr_w1, in_item.addr_w2, in_item.addr_w3};
    end
    if (ctl.decide) begin
      mode_r     <= mode;
      len_r      <= len;
      pos_r      <= 6'd0;
      idx_byte_r <= next_idx_r;
    end
    if (ctl.emit) begin
      pos_r <= pos_r + 6'd1;
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
endmodule
`default_nettype wire

FILE: hdl/mesh_address_abbreviation_encoder.sv
// Top level of the mesh address abbreviation encoder.
// An encode word gives 1 to 34 output bytes, one byte per cycle; busy stays high until
// its last byte is emitted, so the next word is not taken before then.
// Set sender, unset sender and clear previous words give no bytes and leave busy low.
// After reset the block sweeps the cache and slot memories with busy high.
// The receiver cannot stall the byte stream.
`default_nettype none
`include "mesh_address_abbreviation_encoder_assert.svh"
module mesh_address_abbreviation_encoder import maae_pkg::*; #(
  parameter int unsigned CACHE_ENTRIES = CacheEntriesDef
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_valid,
  output out_item_t     out_item
);
  ctl_t ctl;
  sts_t sts;

  maae_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .cmd(in_item.cmd),
    .sts(sts), .ctl(ctl), .busy(busy)
  );

  maae_dp #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .ctl(ctl), .sts(sts),
    .out_valid(out_valid), .out_item(out_item)
  );

  `MAAE_ASSERT_NEXT(a_encode_busy, start && !busy && in_item.cmd == CMD_ENCODE, busy)
  `MAAE_ASSERT_IMP(a_err_last, out_valid && out_item.status, out_item.last)
  `MAAE_ASSERT_IMP(a_err_zero, out_valid && out_item.status, out_item.out_byte == 8'h00)
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for the mesh address abbreviation encoder: random and directed words, scored per byte.
`default_nettype none
module tb_top;
  import maae_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CacheEntries = CacheEntriesDef;
  localparam int unsigned IdleLimit = 20000;

  // Scoreboard with its own copy of the encoder state.
  class abbrev_scoreboard;
    logic [255:0] cache_line [CacheEntries];
    logic [7:0]   slot_idx [512];
    logic [7:0]   next_idx;
    logic [255:0] prev_addr;
    logic [255:0] sender;
    bit           sender_on;
    out_item_t    pending_bytes[$];
    int           mismatches;

    function new();
      foreach (cache_line[i]) cache_line[i] = '0;
      foreach (slot_idx[i]) slot_idx[i] = '0;
      next_idx = 8'd1;
      prev_addr = '0;
      sender = '0;
      sender_on = 0;
      mismatches = 0;
    endfunction

    function void push_byte(logic [7:0] b, logic st);
      out_item_t o;
      o.out_byte = b;
      o.last = 1'b0;
      o.status = st;
      pending_bytes.push_back(o);
    endfunction

    function void push_span(logic [255:0] a, int from, int upto);
      for (int i = from; i < upto; i++) push_byte(a[255 - 8 * i -: 8], 1'b0);
    endfunction

    function void note_word(in_item_t w);
      logic [255:0] a;
      logic [23:0]  top;
      int unsigned  idx;
      int unsigned  shamt;
      int unsigned  s;
      logic [7:0]   first;
      bit           hit;
      a = {w.addr_w0, w.addr_w1, w.addr_w2, w.addr_w3};
      case (w.cmd)
        CMD_SET_SENDER: begin
          sender = a;
          sender_on = 1;
        end
        CMD_UNSET: sender_on = 0;
        CMD_CLEAR_PREV: prev_addr[255:248] = 8'h00;
        default: begin
          shamt = 24 - cache_lg(CacheEntries);
          top = a[255:232];
          idx = (top >> shamt) ^ 1;
          if (idx >= CacheEntries) idx = 0;
          hit = (cache_line[idx] == a);
          if (!hit) cache_line[idx] = a;
          first = a[255:248];
          if (first < MIN_FIRST) begin
            push_byte(8'h00, 1'b1);
            pending_bytes[$].last = 1'b1;
          end else begin
            if (sender_on && a == sender) push_byte(CODE_SELF, 1'b0);
            else if (a == prev_addr) push_byte(CODE_PREV, 1'b0);
            else if (a[255:64] == '1) begin
              push_byte(CODE_BCAST, 1'b0);
              push_span(a, 24, 32);
            end else begin
              s = 0;
              while (s < 2 && slot_idx[first * 2 + s] != 0) s++;
              if (s < 2 && next_idx != 0) begin
                slot_idx[first * 2 + s] = next_idx;
                push_byte(CODE_FULL, 1'b0);
                push_span(a, 0, 32);
                push_byte(next_idx, 1'b0);
                next_idx++;
              end else if (hit) begin
                push_byte(CODE_PREFIX, 1'b0);
                push_span(a, 0, 7);
              end else push_span(a, 0, 32);
            end
            pending_bytes[$].last = 1'b1;
            prev_addr = a;
          end
        end
      endcase
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected byte %h", got);
        return;
      end
      want = pending_bytes.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("byte: expected %h/%b/%b got %h/%b/%b", want.out_byte, want.last,
                   want.status, got.out_byte, got.last, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  abbrev_scoreboard sb = new();
  int idle_cycles = 0;
  logic [255:0] recent[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mesh_address_abbreviation_encoder #(.CACHE_ENTRIES(CacheEntries)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_byte(out_item);
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("mesh_address_abbreviation_encoder: mismatch");
      $finish;
    end
  end

  // After a random gap with start low, hold the word until the block takes it.
  task automatic send_word(logic [1:0] c, logic [255:0] a);
    int gap;
    bit taken;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= {c, a};
    start <= 1'b1;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    sb.note_word({c, a});
    if (c == CMD_ENCODE) recent.push_back(a);
    if (recent.size() > 16) void'(recent.pop_front());
    @(negedge clk);
  endtask

  function automatic logic [255:0] rand_addr();
    logic [255:0] a;
    for (int i = 0; i < 8; i++) a[32 * i +: 32] = $urandom;
    return a;
  endfunction

  task automatic random_word();
    logic [255:0] a;
    int pick;
    logic [1:0] c;
    pick = $urandom_range(0, 99);
    a = rand_addr();
    // Few first bytes so the slot table fills and prefix codes appear.
    if ($urandom_range(0, 3) != 0) a[255:248] = 8'(8'h10 + $urandom_range(0, 7));
    if (pick < 30 && recent.size() > 0) a = recent[$urandom_range(0, recent.size() - 1)];
    else if (pick < 36) a[255:64] = '1;
    else if (pick < 42) a[255:252] = 4'h0;
    c = CMD_ENCODE;
    pick = $urandom_range(0, 99);
    if (pick < 5) c = CMD_SET_SENDER;
    else if (pick < 8) c = CMD_UNSET;
    else if (pick < 11) c = CMD_CLEAR_PREV;
    send_word(c, a);
  endtask

  initial begin
    logic [255:0] a;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Directed: extremes, every command, invalid, self, previous, broadcast, full and raw.
    send_word(CMD_ENCODE, '0);
    send_word(CMD_ENCODE, {8'h0f, {31{8'hff}}});
    send_word(CMD_ENCODE, '1);
    send_word(CMD_ENCODE, '1);
    send_word(CMD_CLEAR_PREV, '0);
    send_word(CMD_ENCODE, '1);
    a = {8'h10, 248'h0};
    send_word(CMD_ENCODE, a);
    send_word(CMD_ENCODE, a);
    send_word(CMD_SET_SENDER, a);
    send_word(CMD_ENCODE, a);
    send_word(CMD_UNSET, a);
    send_word(CMD_CLEAR_PREV, a);
    send_word(CMD_ENCODE, a);
    send_word(CMD_ENCODE, {8'h10, 248'h1});
    send_word(CMD_ENCODE, {8'h10, 248'h2});
    send_word(CMD_ENCODE, {8'h10, 248'h1});
    send_word(CMD_ENCODE, {8'hff, 8'h00, {30{8'hff}}});
    send_word(CMD_ENCODE, {8'hff, 248'h0});
    send_word(CMD_ENCODE, {8'hff, 248'h0} ^ 256'h1);
    send_word(CMD_ENCODE, {8'hff, 8'h00, {30{8'hff}}});
    // Run the index counter past its wrap.
    for (int i = 0; i < 60; i++) random_word();
    for (int i = 0; i < 250; i++)
      send_word(CMD_ENCODE, {8'(8'h10 + i % 240), 248'(rand_addr())});
    for (int i = 0; i < 20; i++) random_word();
    start <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (sb.mismatches == 0) $display("mesh_address_abbreviation_encoder: match");
    else $display("mesh_address_abbreviation_encoder: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
